>>> sv/frtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frtc_pkg: shared types and constants of the frame rate trend classifier
// Field widths, arithmetic constants, class codes, register indexes, the
// controller state type and the command/status bundles.
// ----------------------------------------------------------------------------
package frtc_pkg;

    // Field and register widths
    localparam int STAMP_W    = 63;
    localparam int STEP_W     = 8;
    localparam int THR_W      = 12;
    localparam int RATE_W     = 12;
    localparam int CLASS_W    = 3;
    localparam int OUT_DATA_W = 16;
    localparam int IN_DATA_W  = 64;

    // Arithmetic widths: diff <= 2e9, den = step * diff < 2^39,
    // numerator 2e9 + den and divisor 2 * den both < 2^40
    localparam int DIFF_W    = 31;
    localparam int DEN_W     = 39;
    localparam int DIV_W     = 40;
    localparam int DIV_CNT_W = 6;
    localparam int PROD_W    = RATE_W + STEP_W;

    localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(DIV_W - 1);
    localparam logic [STAMP_W-1:0]   DIFF_LIMIT   = 63'd2000000000;
    localparam logic [DIV_W-1:0]     ROUND_BIAS   = 40'd2000000000;
    localparam logic [RATE_W-1:0]    RATE_MAX     = 12'd4095;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESH = 1'd1;
    localparam logic [STEP_W-1:0]    RATE_STEP_RST  = 8'd5;
    localparam logic [THR_W-1:0]     LOW_THRESH_RST = 12'd60;

    // Trend class codes, checked in this order
    typedef enum logic [CLASS_W-1:0] {
        TREND_STABLE   = 3'd0,
        TREND_LOW      = 3'd1,
        TREND_RISING   = 3'd2,
        TREND_FALLING  = 3'd3,
        TREND_PEAK     = 3'd4,
        TREND_UNSTABLE = 3'd5
    } trend_class_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EVAL,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_SCALE,
        ST_PUSH,
        ST_EMIT
    } frtc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_stamp;
        logic check;
        logic rate_zero;
        logic mul;
        logic div_init;
        logic div_step;
        logic scale;
        logic push;
        logic emit;
    } frtc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic skip;
        logic big_gap;
        logic div_last;
        logic full_after_push;
        logic out_free;
    } frtc_sts_t;

endpackage

>>> sv/frtc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frtc_ctrl: sequencing controller
// Walks one accepted stamp through difference, multiply, bit-serial divide,
// scaling, window push and result hand-off; skipped stamps and big gaps cut it short.
// ----------------------------------------------------------------------------
module frtc_ctrl
    import frtc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  frtc_sts_t sts,
    output frtc_cmd_t cmd
);

    frtc_state_t state_reg;
    frtc_state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                priority if (sts.skip) begin
                    state_next = ST_IDLE;
                end else if (sts.big_gap) begin
                    state_next = ST_PUSH;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_last) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                state_next = ST_PUSH;
            end
            ST_PUSH: begin
                state_next = sts.full_after_push ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                cmd.load_stamp = s_tvalid;
            end
            ST_CHECK: begin
                cmd.check = 1'b1;
            end
            ST_EVAL: begin
                cmd.rate_zero = !sts.skip && sts.big_gap;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_SCALE: begin
                cmd.scale = 1'b1;
            end
            ST_PUSH: begin
                cmd.push = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/frtc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frtc_datapath: arithmetic, rate window and output register
// Holds the previous stamp, the configuration registers, the restoring
// divider, the rate window with its fill count, the classifier and the
// result register.
// ----------------------------------------------------------------------------
module frtc_datapath
    import frtc_pkg::*;
#(
    parameter int WINDOW_LENGTH = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  frtc_cmd_t             cmd,
    output frtc_sts_t             sts,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [STAMP_W-1:0]    stamp_in,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
    localparam int MID    = WINDOW_LENGTH / 2;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LENGTH);
    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW_LENGTH - 1);

    // Configuration
    logic [STEP_W-1:0] rate_step_reg;
    logic [THR_W-1:0]  low_thresh_reg;
    logic [STEP_W-1:0] step_eff;

    // Stamp and difference
    logic [STAMP_W-1:0] stamp_reg;
    logic [STAMP_W-1:0] prev_stamp_reg;
    logic [STAMP_W-1:0] diff_reg;
    logic               borrow_reg;
    logic               prev_zero_reg;
    logic [STAMP_W:0]   diff_full;

    // Multiply and divide
    logic [DEN_W-1:0]     den_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     dvs_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_W:0]       trial;
    logic                 trial_ge;

    // Scaling
    logic [PROD_W-1:0] prod;
    logic              sat;
    logic [RATE_W-1:0] rate_reg;

    // Window
    logic [RATE_W-1:0] win_reg [WINDOW_LENGTH];
    logic [FILL_W-1:0] fill_reg;
    logic              full_now;

    // Classification
    trend_class_t cls;

    // Output register
    logic                  m_tvalid_reg;
    logic [CLASS_W-1:0]    out_class_reg;
    logic [RATE_W-1:0]     out_rate_reg;

    assign step_eff = (rate_step_reg == '0) ? STEP_W'(1) : rate_step_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_step_reg  <= RATE_STEP_RST;
            low_thresh_reg <= LOW_THRESH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RATE_STEP:  rate_step_reg  <= cfg_wdata[STEP_W-1:0];
                CFG_LOW_THRESH: low_thresh_reg <= cfg_wdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stamp capture, difference against the stored stamp
    assign diff_full = {1'b0, stamp_reg} - {1'b0, prev_stamp_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_stamp_reg <= '0;
        end else if (cmd.check) begin
            prev_stamp_reg <= stamp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_stamp) begin
            stamp_reg <= stamp_in;
        end
        if (cmd.check) begin
            diff_reg      <= diff_full[STAMP_W-1:0];
            borrow_reg    <= diff_full[STAMP_W];
            prev_zero_reg <= (prev_stamp_reg == '0);
        end
    end

    assign sts.skip    = prev_zero_reg || borrow_reg || (diff_reg == '0);
    assign sts.big_gap = (diff_reg > DIFF_LIMIT);

    // Denominator step * diff, then restoring division one bit a cycle
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            den_reg <= DEN_W'(step_eff) * diff_reg[DIFF_W-1:0];
        end
        if (cmd.div_init) begin
            quo_reg     <= ROUND_BIAS + DIV_W'(den_reg);
            dvs_reg     <= {den_reg, 1'b0};
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            // remainder stays below the divisor, so the top bit is always zero
            rem_reg     <= trial_ge ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
            quo_reg     <= {quo_reg[DIV_W-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    assign sts.div_last = (div_cnt_reg == DIV_CNT_LAST);

    // Scale quotient by the step and saturate
    assign prod = quo_reg[RATE_W-1:0] * step_eff;
    assign sat  = (quo_reg[DIV_W-1:RATE_W] != '0) || (prod[PROD_W-1:RATE_W] != '0);

    always_ff @(posedge aclk) begin
        if (cmd.rate_zero) begin
            rate_reg <= '0;
        end else if (cmd.scale) begin
            rate_reg <= sat ? RATE_MAX : prod[RATE_W-1:0];
        end
    end

    // Rate window: fill in place, then shift out the oldest entry
    assign full_now            = (fill_reg >= FILL_FULL);
    assign sts.full_after_push = (fill_reg >= FILL_LAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (cmd.push && !full_now) begin
            fill_reg <= fill_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            if (full_now) begin
                for (int i = 0; i < WINDOW_LENGTH - 1; i++) begin
                    win_reg[i] <= win_reg[i + 1];
                end
                win_reg[WINDOW_LENGTH - 1] <= rate_reg;
            end else begin
                for (int i = 0; i < WINDOW_LENGTH; i++) begin
                    if (fill_reg == FILL_W'(i)) begin
                        win_reg[i] <= rate_reg;
                    end
                end
            end
        end
    end

    // Classifier over the full window, entry 0 oldest
    always_comb begin
        logic eq;
        logic low;
        logic up;
        logic down;
        eq   = 1'b1;
        low  = 1'b1;
        up   = 1'b1;
        down = 1'b1;
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            if (win_reg[i] >= low_thresh_reg) begin
                low = 1'b0;
            end
            if (i > 0) begin
                if (win_reg[i] != win_reg[0]) begin
                    eq = 1'b0;
                end
                if (win_reg[i] <= win_reg[i - 1]) begin
                    up = 1'b0;
                end
                if (win_reg[i] >= win_reg[i - 1]) begin
                    down = 1'b0;
                end
            end
        end
        priority if (eq) begin
            cls = TREND_STABLE;
        end else if (low) begin
            cls = TREND_LOW;
        end else if (up) begin
            cls = TREND_RISING;
        end else if (down) begin
            cls = TREND_FALLING;
        end else if (win_reg[MID] >= win_reg[MID - 1] && win_reg[MID] >= win_reg[MID + 1]) begin
            cls = TREND_PEAK;
        end else begin
            cls = TREND_UNSTABLE;
        end
    end

    // Output register
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_class_reg <= cls;
            out_rate_reg  <= rate_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - CLASS_W - RATE_W){1'b0}}, out_rate_reg, out_class_reg};

`ifndef SYNTHESIS
    // Fill count never passes the window length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_FULL)
        else $error("fill count beyond window length");

    // A result only appears once the window is full
    a_result_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> full_now)
        else $error("result from a partial window");

    // Divider never steps past its last bit
    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (div_cnt_reg <= DIV_CNT_LAST))
        else $error("divider overran");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !cmd.emit)
        else $error("pending result overwritten");
`endif

endmodule

>>> sv/frame_rate_trend_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rate_trend_classifier_unit: frame rate trend classifier, top level
// Turns frame timestamps into quantized refresh rates and classifies the
// trend over a sliding window of the most recent rates.
// ----------------------------------------------------------------------------
// Each input word is a frame timestamp in nanoseconds. The first stamp, a
// zero stamp, or a stamp not later than the stored one is only stored.
// Otherwise the rate round(1e9 / (step * diff)) * step, saturated at 4095,
// enters the window; a gap above two seconds gives rate 0, any other stamp
// goes through the 40-step restoring divider that works one quotient bit a
// cycle. Once WINDOW_LENGTH rates are held, every new rate yields one output
// word with the trend class and that rate; handing it to the output register
// stalls for as long as an earlier word there has not been taken. One stamp
// is processed at a time; a finished result waits in the output register
// while the next stamp is taken. Configuration registers: index 0 rate_step
// (0 acts as 1), index 1 low_rate_threshold; write only while idle.
module frame_rate_trend_classifier_unit
    import frtc_pkg::*;
#(
    parameter int WINDOW_LENGTH = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [62:0] timestamp_ns
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [2:0] trend_class, [14:3] newest_rate
);

    frtc_cmd_t cmd;
    frtc_sts_t sts;

    frtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    frtc_datapath #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .stamp_in  (s_tdata[STAMP_W-1:0]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
